>>> rtl/krlt_pkg.sv
// Shared types and constants for the key repeat and long-press translator.
// Used by every module of the block; depends on nothing.
package krlt_pkg;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] ESC_BYTE     = 8'h1b;
   localparam logic [7:0] BRACKET_BYTE = 8'h5b;
   localparam logic [7:0] UP_FINAL     = 8'h41;
   localparam logic [7:0] DOWN_FINAL   = 8'h42;
   localparam logic [7:0] BACK_FINAL   = 8'h44;
   localparam logic [7:0] LP_DOWN_BYTE = 8'h73;
   localparam logic [7:0] LP_UP_BYTE   = 8'h65;
   localparam logic [7:0] LP_NONE_BYTE = 8'h20;

   localparam logic [15:0] DEBOUNCE_RESET  = 16'd50;
   localparam logic [15:0] FIRST_RESET     = 16'd500;
   localparam logic [15:0] NEXT_RESET      = 16'd200;
   localparam logic [8:0]  VOL_UP_RESET    = 9'd277;
   localparam logic [8:0]  VOL_DOWN_RESET  = 9'd278;
   localparam logic [8:0]  BACK_RESET      = 9'd263;

   localparam int unsigned CSR_ADDR_W = 5;
   localparam int unsigned CSR_DATA_W = 32;

   typedef enum logic [2:0] {
      REG_DEBOUNCE    = 3'd0,
      REG_FIRST       = 3'd1,
      REG_NEXT        = 3'd2,
      REG_VOL_UP      = 3'd3,
      REG_VOL_DOWN    = 3'd4,
      REG_BACK        = 3'd5
   } reg_index_type;

   typedef enum logic [1:0] {
      PH_RELEASED   = 2'd0,
      PH_PRESSED    = 2'd1,
      PH_LP_WAIT    = 2'd2,
      PH_LP_RELEASE = 2'd3
   } phase_type;

   typedef struct packed {
      phase_type   phase;
      logic [15:0] timer;
      logic        repeating;
      logic        lp_done;
   } entry_type;

   typedef struct packed {
      logic [15:0] release_debounce_ms;
      logic [15:0] first_repeat_ms;
      logic [15:0] next_repeat_ms;
      logic [8:0]  volume_up_code;
      logic [8:0]  volume_down_code;
      logic [8:0]  back_code;
   } cfg_type;

   // seq set: emit ESC '[' code; clear: emit code alone
   typedef struct packed {
      logic       seq;
      logic [7:0] code;
   } event_type;

   typedef enum logic [1:0] {
      F_CLEAR,
      F_IDLE,
      F_LOOKUP,
      F_UPDATE
   } front_state_type;

   typedef enum logic [1:0] {
      B_IDLE,
      B_ESC,
      B_BRACKET,
      B_FINAL
   } back_state_type;

endpackage

>>> rtl/krlt_front.sv
// Front end: accepts key reports, owns the per-key table and its clearing pass,
// and turns each report into at most one byte event. Depends on krlt_pkg.
module krlt_front #(
   parameter int unsigned KEY_COUNT = 511
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [8:0]          req_key_code,
   input  logic                req_pressed,
   input  logic [15:0]         req_elapsed_ms,
   input  logic                req_longpress_enabled,
   input  logic                req_vol_up_held,
   input  logic                req_vol_down_held,
   input  krlt_pkg::cfg_type   cfg,
   output logic                push_valid,
   input  logic                push_ready,
   output krlt_pkg::event_type push_event
);

   localparam int unsigned AW = $clog2(KEY_COUNT);
   localparam logic [10:0] KEY_LIMIT = 11'(KEY_COUNT);
   localparam logic [AW-1:0] LAST_INDEX = AW'(KEY_COUNT - 1);

   krlt_pkg::entry_type       key_table_mem [KEY_COUNT];
   krlt_pkg::entry_type       entry_rd_ff;

   krlt_pkg::front_state_type state_ff, state_in;
   logic [AW-1:0]             clr_idx_ff, clr_idx_in;

   logic [8:0]                key_ff;
   logic [AW-1:0]             addr_ff;
   logic                      level_ff;
   logic [15:0]               dt_ff;
   logic                      lp_en_ff;
   logic                      vup_ff;
   logic                      vdn_ff;

   logic                      accept;
   logic                      in_range;
   logic                      mem_we;
   logic [AW-1:0]             mem_waddr;
   krlt_pkg::entry_type       mem_wdata;

   logic [16:0]               sum;
   logic [15:0]               t;
   logic                      is_up, is_down, is_back;
   logic                      press_ok;
   krlt_pkg::event_type       press_ev;
   krlt_pkg::entry_type       upd;
   logic                      ev_valid;
   krlt_pkg::event_type       ev;
   logic                      commit;

   assign accept   = req_valid && !req_stall;
   assign in_range = {2'b00, req_key_code} < KEY_LIMIT;
   assign req_stall = (state_ff != krlt_pkg::F_IDLE);

   always_ff @(posedge clock) begin
      if (accept) begin
         key_ff   <= req_key_code;
         addr_ff  <= AW'(req_key_code);
         level_ff <= req_pressed;
         dt_ff    <= req_elapsed_ms;
         lp_en_ff <= req_longpress_enabled;
         vup_ff   <= req_vol_up_held;
         vdn_ff   <= req_vol_down_held;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         key_table_mem[mem_waddr] <= mem_wdata;
      end
      entry_rd_ff <= key_table_mem[addr_ff];
   end

   always_comb begin
      sum = {1'b0, entry_rd_ff.timer} + {1'b0, dt_ff};
      t   = sum[16] ? 16'hffff : sum[15:0];

      is_up   = (key_ff == cfg.volume_up_code);
      is_down = (key_ff == cfg.volume_down_code);
      is_back = (key_ff == cfg.back_code);
      press_ok = !key_ff[8] || is_up || is_down || is_back;
      if (!key_ff[8]) begin
         press_ev = '{seq: 1'b0, code: key_ff[7:0]};
      end else if (is_up) begin
         press_ev = '{seq: 1'b1, code: krlt_pkg::UP_FINAL};
      end else if (is_down) begin
         press_ev = '{seq: 1'b1, code: krlt_pkg::DOWN_FINAL};
      end else begin
         press_ev = '{seq: 1'b1, code: krlt_pkg::BACK_FINAL};
      end

      upd       = entry_rd_ff;
      upd.timer = t;
      ev_valid  = 1'b0;
      ev        = press_ev;

      unique case (entry_rd_ff.phase)
         krlt_pkg::PH_RELEASED: begin
            if (level_ff) begin
               ev_valid  = !lp_en_ff && press_ok;
               upd.timer = '0;
               upd.phase = lp_en_ff ? krlt_pkg::PH_LP_WAIT : krlt_pkg::PH_PRESSED;
            end
         end
         krlt_pkg::PH_PRESSED: begin
            if (!level_ff && t > cfg.release_debounce_ms) begin
               upd = '0;
            end else if ((entry_rd_ff.repeating && t >= cfg.next_repeat_ms) ||
                         t >= cfg.first_repeat_ms) begin
               ev_valid      = press_ok;
               upd.timer     = '0;
               upd.repeating = 1'b1;
            end
         end
         krlt_pkg::PH_LP_WAIT: begin
            if (level_ff) begin
               if (!entry_rd_ff.lp_done && t >= cfg.first_repeat_ms) begin
                  ev_valid = 1'b1;
                  ev.seq   = 1'b0;
                  if (vdn_ff) begin
                     ev.code = krlt_pkg::LP_DOWN_BYTE;
                  end else if (vup_ff) begin
                     ev.code = krlt_pkg::LP_UP_BYTE;
                  end else begin
                     ev.code = krlt_pkg::LP_NONE_BYTE;
                  end
                  upd.lp_done = 1'b1;
               end
            end else if (!entry_rd_ff.lp_done) begin
               ev_valid  = press_ok;
               upd.phase = krlt_pkg::PH_LP_RELEASE;
            end else if (t > cfg.release_debounce_ms) begin
               upd = '0;
            end
         end
         default: begin
            upd = '0;
         end
      endcase
   end

   always_comb begin
      state_in   = state_ff;
      clr_idx_in = clr_idx_ff;
      mem_we     = 1'b0;
      mem_waddr  = addr_ff;
      mem_wdata  = upd;
      push_valid = 1'b0;
      push_event = ev;
      commit     = 1'b0;

      unique case (state_ff)
         krlt_pkg::F_CLEAR: begin
            mem_we     = 1'b1;
            mem_waddr  = clr_idx_ff;
            mem_wdata  = '0;
            clr_idx_in = clr_idx_ff + 1'b1;
            if (clr_idx_ff == LAST_INDEX) begin
               state_in = krlt_pkg::F_IDLE;
            end
         end
         krlt_pkg::F_IDLE: begin
            if (accept && in_range) begin
               state_in = krlt_pkg::F_LOOKUP;
            end
         end
         krlt_pkg::F_LOOKUP: begin
            state_in = krlt_pkg::F_UPDATE;
         end
         default: begin
            commit     = !ev_valid || push_ready;
            push_valid = ev_valid;
            mem_we     = commit;
            if (commit) begin
               state_in = krlt_pkg::F_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= krlt_pkg::F_CLEAR;
         clr_idx_ff <= '0;
      end else begin
         state_ff   <= state_in;
         clr_idx_ff <= clr_idx_in;
      end
   end

endmodule

>>> rtl/krlt_queue.sv
// Short event queue between the front and back ends.
// Depends on krlt_pkg for the event type and depth.
module krlt_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  krlt_pkg::event_type push_event,
   output logic                pop_valid,
   input  logic                pop_ready,
   output krlt_pkg::event_type pop_event
);

   krlt_pkg::event_type                   slot_ff [krlt_pkg::QUEUE_DEPTH];
   logic [krlt_pkg::QUEUE_PTR_W-1:0]      wr_ptr_ff, rd_ptr_ff;
   logic [krlt_pkg::QUEUE_CNT_W-1:0]      count_ff;
   logic                                  do_push, do_pop;

   assign push_ready = (count_ff != krlt_pkg::QUEUE_CNT_W'(krlt_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_event  = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_event;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

>>> rtl/krlt_back.sv
// Back end: expands queued events into output bytes, one per beat,
// through a registered output stage. Depends on krlt_pkg.
module krlt_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                pop_valid,
   output logic                pop_ready,
   input  krlt_pkg::event_type pop_event,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_out_byte,
   output logic                rsp_last_of_run
);

   krlt_pkg::back_state_type state_ff, state_in;
   logic [7:0]               code_ff, code_in;
   logic                     valid_ff, valid_in;
   logic [7:0]               byte_ff, byte_in;
   logic                     last_ff, last_in;
   logic                     slot_free;

   assign slot_free       = !valid_ff || !rsp_stall;
   assign rsp_valid       = valid_ff;
   assign rsp_out_byte    = byte_ff;
   assign rsp_last_of_run = last_ff;

   always_comb begin
      state_in  = state_ff;
      code_in   = code_ff;
      valid_in  = valid_ff && rsp_stall;
      byte_in   = byte_ff;
      last_in   = last_ff;
      pop_ready = 1'b0;

      unique case (state_ff)
         krlt_pkg::B_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               code_in  = pop_event.code;
               state_in = pop_event.seq ? krlt_pkg::B_ESC : krlt_pkg::B_FINAL;
            end
         end
         krlt_pkg::B_ESC: begin
            if (slot_free) begin
               valid_in = 1'b1;
               byte_in  = krlt_pkg::ESC_BYTE;
               last_in  = 1'b0;
               state_in = krlt_pkg::B_BRACKET;
            end
         end
         krlt_pkg::B_BRACKET: begin
            if (slot_free) begin
               valid_in = 1'b1;
               byte_in  = krlt_pkg::BRACKET_BYTE;
               last_in  = 1'b0;
               state_in = krlt_pkg::B_FINAL;
            end
         end
         default: begin
            if (slot_free) begin
               valid_in = 1'b1;
               byte_in  = code_ff;
               last_in  = 1'b1;
               state_in = krlt_pkg::B_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      code_ff <= code_in;
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= krlt_pkg::B_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

endmodule

>>> rtl/key_repeat_longpress_translator.sv
// Top level of the key repeat and long-press translator: configuration
// registers and the front end, event queue and back end. Depends on krlt_pkg.
//
// After reset the block sweeps its key table clear, one entry per cycle, with
// req_stall high (configuration writes are taken). Each key report then goes
// through accept, a registered table read, and update and write back, which
// waits while an event is due and the queue is full; a report whose key_code
// is KEY_COUNT or above is accepted and dropped. Bytes leave the back end at
// one per beat: a plain byte via the final-byte state, an escape sequence via
// the escape, bracket and final-byte states. A four-entry event queue lets the
// front end keep taking reports while the output side stalls, until it fills.
module key_repeat_longpress_translator #(
   parameter int unsigned KEY_COUNT = 511
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [8:0]  req_key_code,
   input  logic        req_pressed,
   input  logic [15:0] req_elapsed_ms,
   input  logic        req_longpress_enabled,
   input  logic        req_vol_up_held,
   input  logic        req_vol_down_held,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last_of_run,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [krlt_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [krlt_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [krlt_pkg::CSR_DATA_W-1:0] prdata,
   output logic        pready
);

   krlt_pkg::cfg_type       cfg_ff;
   krlt_pkg::reg_index_type reg_idx;
   logic                    csr_write;

   logic                    push_valid, push_ready;
   krlt_pkg::event_type     push_event;
   logic                    pop_valid, pop_ready;
   krlt_pkg::event_type     pop_event;

   assign pready    = 1'b1;
   assign reg_idx   = krlt_pkg::reg_index_type'(paddr[4:2]);
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.release_debounce_ms <= krlt_pkg::DEBOUNCE_RESET;
         cfg_ff.first_repeat_ms     <= krlt_pkg::FIRST_RESET;
         cfg_ff.next_repeat_ms      <= krlt_pkg::NEXT_RESET;
         cfg_ff.volume_up_code      <= krlt_pkg::VOL_UP_RESET;
         cfg_ff.volume_down_code    <= krlt_pkg::VOL_DOWN_RESET;
         cfg_ff.back_code           <= krlt_pkg::BACK_RESET;
      end else if (csr_write) begin
         case (reg_idx)
            krlt_pkg::REG_DEBOUNCE: cfg_ff.release_debounce_ms <= pwdata[15:0];
            krlt_pkg::REG_FIRST:    cfg_ff.first_repeat_ms     <= pwdata[15:0];
            krlt_pkg::REG_NEXT:     cfg_ff.next_repeat_ms      <= pwdata[15:0];
            krlt_pkg::REG_VOL_UP:   cfg_ff.volume_up_code      <= pwdata[8:0];
            krlt_pkg::REG_VOL_DOWN: cfg_ff.volume_down_code    <= pwdata[8:0];
            krlt_pkg::REG_BACK:     cfg_ff.back_code           <= pwdata[8:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         krlt_pkg::REG_DEBOUNCE: prdata = {16'b0, cfg_ff.release_debounce_ms};
         krlt_pkg::REG_FIRST:    prdata = {16'b0, cfg_ff.first_repeat_ms};
         krlt_pkg::REG_NEXT:     prdata = {16'b0, cfg_ff.next_repeat_ms};
         krlt_pkg::REG_VOL_UP:   prdata = {23'b0, cfg_ff.volume_up_code};
         krlt_pkg::REG_VOL_DOWN: prdata = {23'b0, cfg_ff.volume_down_code};
         krlt_pkg::REG_BACK:     prdata = {23'b0, cfg_ff.back_code};
         default:                prdata = '0;
      endcase
   end

   krlt_front #(
      .KEY_COUNT (KEY_COUNT)
   ) u_front (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_key_code          (req_key_code),
      .req_pressed           (req_pressed),
      .req_elapsed_ms        (req_elapsed_ms),
      .req_longpress_enabled (req_longpress_enabled),
      .req_vol_up_held       (req_vol_up_held),
      .req_vol_down_held     (req_vol_down_held),
      .cfg                   (cfg_ff),
      .push_valid            (push_valid),
      .push_ready            (push_ready),
      .push_event            (push_event)
   );

   krlt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_event (push_event),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_event  (pop_event)
   );

   krlt_back u_back (
      .clock           (clock),
      .reset           (reset),
      .pop_valid       (pop_valid),
      .pop_ready       (pop_ready),
      .pop_event       (pop_event),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

>>> tb/sv/tb_key_repeat_longpress_translator.sv
// Testbench for key_repeat_longpress_translator: a scoreboard class predicts
// the translated byte beats per key report; plain tasks drive the block.
// Depends on krlt_pkg and the key_repeat_longpress_translator RTL.
`timescale 1ns / 1ps

module tb_key_repeat_longpress_translator;

   localparam int KEY_COUNT     = 511;
   localparam int IDLE_LIMIT    = 4000;
   localparam int SETTLE_CYCLES = 20;
   localparam int PHASE_ITEMS   = 45;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [8:0]  req_key_code;
   logic        req_pressed;
   logic [15:0] req_elapsed_ms;
   logic        req_longpress_enabled;
   logic        req_vol_up_held;
   logic        req_vol_down_held;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_last_of_run;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [krlt_pkg::CSR_ADDR_W-1:0] paddr;
   logic [krlt_pkg::CSR_DATA_W-1:0] pwdata;
   logic [krlt_pkg::CSR_DATA_W-1:0] prdata;
   logic        pready;

   typedef struct {
      logic [8:0]  key_code;
      logic        pressed;
      logic [15:0] elapsed_ms;
      logic        longpress_enabled;
      logic        vol_up_held;
      logic        vol_down_held;
   } key_report_type;

   typedef struct {
      logic [7:0] out_byte;
      logic       last_of_run;
   } byte_beat_type;

   class key_translator_scoreboard;
      krlt_pkg::phase_type phase [KEY_COUNT];
      logic [15:0]         timer [KEY_COUNT];
      logic                repeating [KEY_COUNT];
      logic                lp_done [KEY_COUNT];
      krlt_pkg::cfg_type   cfg;
      logic [7:0]          run_bytes [$];
      byte_beat_type       pending_bytes [$];
      int                  errors;

      function new();
         cfg.release_debounce_ms = krlt_pkg::DEBOUNCE_RESET;
         cfg.first_repeat_ms     = krlt_pkg::FIRST_RESET;
         cfg.next_repeat_ms      = krlt_pkg::NEXT_RESET;
         cfg.volume_up_code      = krlt_pkg::VOL_UP_RESET;
         cfg.volume_down_code    = krlt_pkg::VOL_DOWN_RESET;
         cfg.back_code           = krlt_pkg::BACK_RESET;
         for (int i = 0; i < KEY_COUNT; i++) begin
            release_entry(i);
         end
         errors = 0;
      endfunction

      function void set_reg(krlt_pkg::reg_index_type idx, logic [31:0] value);
         case (idx)
            krlt_pkg::REG_DEBOUNCE: cfg.release_debounce_ms = value[15:0];
            krlt_pkg::REG_FIRST:    cfg.first_repeat_ms     = value[15:0];
            krlt_pkg::REG_NEXT:     cfg.next_repeat_ms      = value[15:0];
            krlt_pkg::REG_VOL_UP:   cfg.volume_up_code      = value[8:0];
            krlt_pkg::REG_VOL_DOWN: cfg.volume_down_code    = value[8:0];
            krlt_pkg::REG_BACK:     cfg.back_code           = value[8:0];
            default: ;
         endcase
      endfunction

      function void release_entry(int k);
         phase[k]     = krlt_pkg::PH_RELEASED;
         timer[k]     = 16'd0;
         repeating[k] = 1'b0;
         lp_done[k]   = 1'b0;
      endfunction

      function void add_press(logic [8:0] k);
         logic [7:0] final_byte;
         logic       special;
         if (k <= 9'd255) begin
            run_bytes.push_back(k[7:0]);
            return;
         end
         special = 1'b1;
         final_byte = 8'd0;
         if (k == cfg.volume_up_code) final_byte = krlt_pkg::UP_FINAL;
         else if (k == cfg.volume_down_code) final_byte = krlt_pkg::DOWN_FINAL;
         else if (k == cfg.back_code) final_byte = krlt_pkg::BACK_FINAL;
         else special = 1'b0;
         if (special) begin
            run_bytes.push_back(krlt_pkg::ESC_BYTE);
            run_bytes.push_back(krlt_pkg::BRACKET_BYTE);
            run_bytes.push_back(final_byte);
         end
      endfunction

      function void predict_report(key_report_type r);
         logic [16:0] sum;
         logic [15:0] t;
         int          k;
         if (r.key_code >= KEY_COUNT) return;
         k = r.key_code;
         run_bytes.delete();
         sum = {1'b0, timer[k]} + {1'b0, r.elapsed_ms};
         t = sum[16] ? 16'hffff : sum[15:0];
         timer[k] = t;
         case (phase[k])
            krlt_pkg::PH_RELEASED: begin
               if (r.pressed) begin
                  if (!r.longpress_enabled) add_press(r.key_code);
                  timer[k] = 16'd0;
                  phase[k] = r.longpress_enabled ? krlt_pkg::PH_LP_WAIT :
                                                   krlt_pkg::PH_PRESSED;
               end
            end
            krlt_pkg::PH_PRESSED: begin
               if (!r.pressed && t > cfg.release_debounce_ms) begin
                  release_entry(k);
               end else if ((repeating[k] && t >= cfg.next_repeat_ms) ||
                            t >= cfg.first_repeat_ms) begin
                  add_press(r.key_code);
                  timer[k] = 16'd0;
                  repeating[k] = 1'b1;
               end
            end
            krlt_pkg::PH_LP_WAIT: begin
               if (r.pressed) begin
                  if (!lp_done[k] && t >= cfg.first_repeat_ms) begin
                     if (r.vol_down_held) run_bytes.push_back(krlt_pkg::LP_DOWN_BYTE);
                     else if (r.vol_up_held) run_bytes.push_back(krlt_pkg::LP_UP_BYTE);
                     else run_bytes.push_back(krlt_pkg::LP_NONE_BYTE);
                     lp_done[k] = 1'b1;
                  end
               end else if (!lp_done[k]) begin
                  add_press(r.key_code);
                  phase[k] = krlt_pkg::PH_LP_RELEASE;
               end else if (t > cfg.release_debounce_ms) begin
                  release_entry(k);
               end
            end
            default: release_entry(k);
         endcase
         foreach (run_bytes[i]) begin
            pending_bytes.push_back('{run_bytes[i], i == run_bytes.size() - 1});
         end
      endfunction

      function void check_byte(logic [7:0] out_byte, logic last_of_run);
         byte_beat_type want;
         if (pending_bytes.size() == 0) begin
            $error("unexpected beat: out_byte %h last_of_run %b", out_byte, last_of_run);
            errors++;
            return;
         end
         want = pending_bytes.pop_front();
         if (out_byte !== want.out_byte) begin
            $error("out_byte: expected %h, actual %h", want.out_byte, out_byte);
            errors++;
         end
         if (last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %b, actual %b", want.last_of_run, last_of_run);
            errors++;
         end
      endfunction
   endclass

   key_translator_scoreboard sb = new();
   int burst_left = 0;
   int stall_tick = 0;
   int stall_mode = 0;

   key_repeat_longpress_translator #(
      .KEY_COUNT(KEY_COUNT)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_key_code(req_key_code),
      .req_pressed(req_pressed),
      .req_elapsed_ms(req_elapsed_ms),
      .req_longpress_enabled(req_longpress_enabled),
      .req_vol_up_held(req_vol_up_held),
      .req_vol_down_held(req_vol_down_held),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_out_byte(rsp_out_byte),
      .rsp_last_of_run(rsp_last_of_run),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // receiver stall pattern: free, random, or long stall blocks
   always @(posedge clock) begin
      stall_tick <= stall_tick + 1;
      if (stall_tick % 128 == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 2) == 0);
         default: rsp_stall <= (stall_tick % 16 < 10);
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_byte(rsp_out_byte, rsp_last_of_run);
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("TB_ERROR");
      $finish;
   end

   function automatic logic coin();
      return 1'($urandom_range(0, 1));
   endfunction

   function automatic logic [15:0] pick_elapsed();
      int span;
      span = sb.cfg.first_repeat_ms;
      if (sb.cfg.release_debounce_ms > span) span = sb.cfg.release_debounce_ms;
      span = span / 2 + 2;
      case ($urandom_range(0, 9))
         0: return 16'd0;
         1: return 16'hffff;
         2: return 16'($urandom);
         default: return 16'($urandom_range(0, span));
      endcase
   endfunction

   function automatic logic [8:0] pick_key();
      case ($urandom_range(0, 5))
         0: return 9'($urandom_range(0, 255));
         1: return sb.cfg.volume_up_code;
         2: return sb.cfg.volume_down_code;
         3: return sb.cfg.back_code;
         4: return 9'($urandom_range(256, 510));
         default: return 9'($urandom_range(0, 7));
      endcase
   endfunction

   task automatic send_report(logic [8:0] key_code, logic pressed, logic [15:0] elapsed_ms,
                              logic lp_en, logic vol_up, logic vol_down);
      key_report_type r;
      r = '{key_code, pressed, elapsed_ms, lp_en, vol_up, vol_down};
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         if ($urandom_range(0, 3) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
      burst_left--;
      req_valid             <= 1'b1;
      req_key_code          <= r.key_code;
      req_pressed           <= r.pressed;
      req_elapsed_ms        <= r.elapsed_ms;
      req_longpress_enabled <= r.longpress_enabled;
      req_vol_up_held       <= r.vol_up_held;
      req_vol_down_held     <= r.vol_down_held;
      do @(posedge clock); while (req_stall);
      sb.predict_report(r);
   endtask

   // drop valid, drain every expected beat, then let the front end finish
   task automatic settle();
      req_valid <= 1'b0;
      burst_left = 0;
      while (sb.pending_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(krlt_pkg::reg_index_type idx, logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      sb.set_reg(idx, value);
   endtask

   task automatic apply_setting(logic [15:0] debounce, logic [15:0] first, logic [15:0] next,
                                logic [8:0] vol_up, logic [8:0] vol_down, logic [8:0] back);
      settle();
      write_reg(krlt_pkg::REG_DEBOUNCE, 32'(debounce));
      write_reg(krlt_pkg::REG_FIRST, 32'(first));
      write_reg(krlt_pkg::REG_NEXT, 32'(next));
      write_reg(krlt_pkg::REG_VOL_UP, 32'(vol_up));
      write_reg(krlt_pkg::REG_VOL_DOWN, 32'(vol_down));
      write_reg(krlt_pkg::REG_BACK, 32'(back));
   endtask

   task automatic random_phase(int item_count);
      int         sent;
      int         holds;
      int         lows;
      logic [8:0] k;
      logic       lp;
      sent = 0;
      while (sent < item_count) begin
         if ($urandom_range(0, 9) < 8) begin
            k = pick_key();
            lp = ($urandom_range(0, 3) == 0);
            holds = $urandom_range(0, 5);
            lows = $urandom_range(1, 3);
            send_report(k, 1'b1, pick_elapsed(), lp, coin(), coin());
            repeat (holds) send_report(k, 1'b1, pick_elapsed(), lp, coin(), coin());
            repeat (lows) send_report(k, 1'b0, pick_elapsed(), lp, coin(), coin());
            sent += 1 + holds + lows;
         end else begin
            send_report(9'($urandom_range(0, 511)), coin(), 16'($urandom),
                        coin(), coin(), coin());
            sent++;
         end
      end
   endtask

   initial begin
      reset                 <= 1'b1;
      req_valid             <= 1'b0;
      req_key_code          <= 9'd0;
      req_pressed           <= 1'b0;
      req_elapsed_ms        <= 16'd0;
      req_longpress_enabled <= 1'b0;
      req_vol_up_held       <= 1'b0;
      req_vol_down_held     <= 1'b0;
      psel                  <= 1'b0;
      penable               <= 1'b0;
      pwrite                <= 1'b0;
      paddr                 <= '0;
      pwdata                <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // plain, special, non-special and out-of-table presses
      send_report(9'd0, 1'b1, 16'd0, 1'b0, 1'b0, 1'b0);
      send_report(9'd255, 1'b1, 16'd0, 1'b0, 1'b0, 1'b0);
      send_report(9'd277, 1'b1, 16'd0, 1'b0, 1'b0, 1'b0);
      send_report(9'd278, 1'b1, 16'd0, 1'b0, 1'b0, 1'b0);
      send_report(9'd263, 1'b1, 16'd0, 1'b0, 1'b0, 1'b0);
      send_report(9'd300, 1'b1, 16'd0, 1'b0, 1'b0, 1'b0);
      send_report(9'd511, 1'b1, 16'hffff, 1'b1, 1'b1, 1'b1);
      // first repeat, next repeat, debounced release
      send_report(9'd0, 1'b1, 16'd500, 1'b0, 1'b0, 1'b0);
      send_report(9'd0, 1'b1, 16'd199, 1'b0, 1'b0, 1'b0);
      send_report(9'd0, 1'b1, 16'd1, 1'b0, 1'b0, 1'b0);
      send_report(9'd0, 1'b0, 16'd30, 1'b0, 1'b0, 1'b0);
      send_report(9'd0, 1'b0, 16'd21, 1'b0, 1'b0, 1'b0);
      // long presses with both, up only and no volume key held
      send_report(9'd10, 1'b1, 16'd0, 1'b1, 1'b0, 1'b0);
      send_report(9'd10, 1'b1, 16'd500, 1'b1, 1'b1, 1'b1);
      send_report(9'd10, 1'b0, 16'd0, 1'b1, 1'b0, 1'b0);
      send_report(9'd11, 1'b1, 16'd0, 1'b1, 1'b0, 1'b0);
      send_report(9'd11, 1'b1, 16'd600, 1'b1, 1'b1, 1'b0);
      send_report(9'd12, 1'b1, 16'd0, 1'b1, 1'b0, 1'b0);
      send_report(9'd12, 1'b1, 16'd500, 1'b1, 1'b0, 1'b0);
      // short tap on a long-press key, then the longpress-release phase
      send_report(9'd277, 1'b0, 16'hffff, 1'b0, 1'b0, 1'b0);
      send_report(9'd277, 1'b1, 16'd0, 1'b1, 1'b0, 1'b0);
      send_report(9'd277, 1'b0, 16'd3, 1'b1, 1'b0, 1'b0);
      send_report(9'd277, 1'b1, 16'd0, 1'b1, 1'b0, 1'b0);
      // timer saturation
      send_report(9'd20, 1'b1, 16'd0, 1'b0, 1'b0, 1'b0);
      send_report(9'd20, 1'b0, 16'd40, 1'b0, 1'b0, 1'b0);
      send_report(9'd20, 1'b1, 16'hffff, 1'b0, 1'b0, 1'b0);

      random_phase(PHASE_ITEMS);
      apply_setting(16'd0, 16'd0, 16'd0, 9'd256, 9'd510, 9'd300);
      random_phase(PHASE_ITEMS);
      apply_setting(16'hffff, 16'hffff, 16'hffff, 9'd510, 9'd510, 9'd256);
      random_phase(PHASE_ITEMS);
      apply_setting(16'($urandom_range(0, 100)), 16'($urandom_range(100, 400)),
                    16'($urandom_range(20, 150)), 9'($urandom_range(256, 510)),
                    9'($urandom_range(256, 510)), 9'd5);
      random_phase(PHASE_ITEMS);
      apply_setting(krlt_pkg::DEBOUNCE_RESET, krlt_pkg::FIRST_RESET, krlt_pkg::NEXT_RESET,
                    krlt_pkg::VOL_UP_RESET, krlt_pkg::VOL_DOWN_RESET, krlt_pkg::BACK_RESET);
      random_phase(PHASE_ITEMS);

      settle();
      if (sb.errors == 0 && sb.pending_bytes.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

>>> key_repeat_longpress_translator.f
rtl/krlt_pkg.sv
rtl/krlt_front.sv
rtl/krlt_queue.sv
rtl/krlt_back.sv
rtl/key_repeat_longpress_translator.sv
tb/sv/tb_key_repeat_longpress_translator.sv
